@@ rtl/rpn_tok_pkg.sv @@
// ---------------------------------------------------------------------------
// rpn_tok_pkg
// Shared types, token codes, character codes and helpers for the expression
// tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none

package rpn_tok_pkg;

  localparam int MANT_W         = 60;
  localparam int FRAC_W         = 5;
  localparam int KIND_W         = 3;
  localparam int DEF_MAX_DIGITS = 18;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_PLUS    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_MINUS   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_STAR    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SLASH   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PERCENT = 3'd4;
  localparam logic [KIND_W-1:0] KIND_COMMA   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_NUMBER  = 3'd6;

  localparam logic [7:0] CH_PLUS    = "+";
  localparam logic [7:0] CH_MINUS   = "-";
  localparam logic [7:0] CH_STAR    = "*";
  localparam logic [7:0] CH_SLASH   = "/";
  localparam logic [7:0] CH_PERCENT = "%";
  localparam logic [7:0] CH_COMMA   = ",";
  localparam logic [7:0] CH_DOT     = ".";
  localparam logic [7:0] CH_ZERO    = "0";
  localparam logic [7:0] CH_NINE    = "9";

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [MANT_W-1:0] mantissa;
    logic [FRAC_W-1:0] frac_digits;
    logic              overflow;
    logic              last_of_run;
  } token_t;

  // Tokens produced by one character: count is 0, 1 or 2, first goes out first.
  typedef struct packed {
    logic [1:0] count;
    token_t     first;
    token_t     second;
  } push_t;

  // Largest mantissa with the given number of decimal digits.
  function automatic logic [MANT_W-1:0] mant_limit(input int digits);
    logic [63:0] lim;
    lim = 64'd1;
    for (int i = 0; i < digits && i < 18; i++) begin
      lim = lim * 64'd10;
    end
    lim = lim - 64'd1;
    return lim[MANT_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/rpn_tok_scan.sv @@
// ---------------------------------------------------------------------------
// rpn_tok_scan
// Input register, scan state and token generation. One character is
// processed per cycle when the output queue has room for two tokens.
// ---------------------------------------------------------------------------
`default_nettype none

module rpn_tok_scan #(
  parameter int MAX_DIGITS = rpn_tok_pkg::DEF_MAX_DIGITS
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [7:0]         ch,
  input  wire logic               end_of_text,
  input  wire logic               room,
  output rpn_tok_pkg::push_t      push
);
  import rpn_tok_pkg::*;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_INT  = 2'd1;
  localparam logic [1:0] MODE_DOT  = 2'd2;
  localparam logic [1:0] MODE_FRAC = 2'd3;

  localparam logic [MANT_W-1:0] LIMIT    = mant_limit(MAX_DIGITS);
  localparam logic [FRAC_W-1:0] FRAC_MAX = FRAC_W'(MAX_DIGITS);

  logic              held;
  logic [7:0]        ch_q;
  logic              eot_q;
  logic [1:0]        mode;
  logic [MANT_W-1:0] digit_value;
  logic [FRAC_W-1:0] fraction_count;
  logic              saturated;

  logic [1:0]        mode_next;
  logic [MANT_W-1:0] digit_value_next;
  logic [FRAC_W-1:0] fraction_count_next;
  logic              saturated_next;

  logic              go;
  logic              dig_hit;
  logic [3:0]        digit;
  logic              op_hit;
  logic [KIND_W-1:0] op_kind;
  logic              flush_pre;
  logic              flush_post;
  logic              op_emit;
  logic              start;
  logic              take_en;
  logic              take_frac;
  logic [1:0]        mode_mid;
  logic [MANT_W-1:0] base_v;
  logic [FRAC_W-1:0] base_fc;
  logic              base_sat;
  logic [63:0]       cand;
  logic              over;
  logic [MANT_W-1:0] v_mid;
  logic [FRAC_W-1:0] fc_mid;
  logic              sat_mid;
  token_t            num_old;
  token_t            num_mid;
  token_t            op_tok;

  assign go       = held & room;
  assign in_ready = ~held | go;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ch_q  <= ch;
      eot_q <= end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_IDLE;
      digit_value    <= '0;
      fraction_count <= '0;
      saturated      <= 1'b0;
    end else if (go) begin
      mode           <= mode_next;
      digit_value    <= digit_value_next;
      fraction_count <= fraction_count_next;
      saturated      <= saturated_next;
    end
  end

  assign dig_hit = (ch_q >= CH_ZERO) && (ch_q <= CH_NINE);
  assign digit   = dig_hit ? ch_q[3:0] : 4'd0;

  always_comb begin
    op_hit  = 1'b1;
    op_kind = KIND_PLUS;
    case (ch_q)
      CH_PLUS:    op_kind = KIND_PLUS;
      CH_MINUS:   op_kind = KIND_MINUS;
      CH_STAR:    op_kind = KIND_STAR;
      CH_SLASH:   op_kind = KIND_SLASH;
      CH_PERCENT: op_kind = KIND_PERCENT;
      CH_COMMA:   op_kind = KIND_COMMA;
      default:    op_hit  = 1'b0;
    endcase
  end

  // Decide what this character does to the number in progress.
  always_comb begin
    flush_pre = 1'b0;
    start     = 1'b0;
    take_en   = 1'b0;
    take_frac = 1'b0;
    mode_mid  = mode;
    case (mode)
      MODE_IDLE: begin
        if (dig_hit && !op_hit) begin
          start    = 1'b1;
          take_en  = 1'b1;
          mode_mid = MODE_INT;
        end
      end
      MODE_INT: begin
        if (dig_hit) begin
          take_en = 1'b1;
        end else if (ch_q == CH_DOT) begin
          mode_mid = MODE_DOT;
        end else begin
          flush_pre = 1'b1;
          mode_mid  = MODE_IDLE;
        end
      end
      MODE_DOT: begin
        if (dig_hit) begin
          take_en   = 1'b1;
          take_frac = 1'b1;
          mode_mid  = MODE_FRAC;
        end else begin
          flush_pre = 1'b1;
          mode_mid  = MODE_IDLE;
        end
      end
      MODE_FRAC: begin
        if (dig_hit) begin
          take_en   = 1'b1;
          take_frac = 1'b1;
        end else begin
          flush_pre = 1'b1;
          mode_mid  = MODE_IDLE;
        end
      end
      default: begin
        mode_mid = MODE_IDLE;
      end
    endcase
  end

  assign op_emit = op_hit && ((mode == MODE_IDLE) || flush_pre);

  // Shift-add by ten with saturation check.
  assign base_v   = (start || flush_pre) ? '0 : digit_value;
  assign base_fc  = (start || flush_pre) ? '0 : fraction_count;
  assign base_sat = (start || flush_pre) ? 1'b0 : saturated;
  assign cand     = ({4'b0, base_v} << 3) + ({4'b0, base_v} << 1) + {60'b0, digit};
  assign over     = (cand > {4'b0, LIMIT}) || (take_frac && (base_fc >= FRAC_MAX));

  always_comb begin
    v_mid   = base_v;
    fc_mid  = base_fc;
    sat_mid = base_sat;
    if (take_en && !base_sat) begin
      if (over) begin
        sat_mid = 1'b1;
        v_mid   = LIMIT;
      end else begin
        v_mid  = cand[MANT_W-1:0];
        fc_mid = base_fc + FRAC_W'(take_frac);
      end
    end
  end

  assign flush_post = eot_q && (mode_mid != MODE_IDLE);

  always_comb begin
    if (flush_post) begin
      mode_next           = MODE_IDLE;
      digit_value_next    = '0;
      fraction_count_next = '0;
      saturated_next      = 1'b0;
    end else begin
      mode_next           = mode_mid;
      digit_value_next    = v_mid;
      fraction_count_next = fc_mid;
      saturated_next      = sat_mid;
    end
  end

  assign num_old = '{KIND_NUMBER, digit_value, fraction_count, saturated, 1'b0};
  assign num_mid = '{KIND_NUMBER, v_mid, fc_mid, sat_mid, 1'b0};
  assign op_tok  = '{op_kind, {MANT_W{1'b0}}, {FRAC_W{1'b0}}, 1'b0, 1'b0};

  always_comb begin
    push.count = go ? ({1'b0, flush_pre} + {1'b0, op_emit} + {1'b0, flush_post}) : 2'd0;
    if (flush_pre) begin
      push.first = num_old;
    end else if (op_emit) begin
      push.first = op_tok;
    end else begin
      push.first = num_mid;
    end
    push.first.last_of_run  = ~(flush_pre & op_emit);
    push.second             = op_tok;
    push.second.last_of_run = 1'b1;
  end

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_IDLE) |-> (digit_value == '0 && fraction_count == '0 && !saturated))
    else $error("idle scan state holds a partial number");

  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    saturated |-> (digit_value == LIMIT))
    else $error("saturated mantissa is not at its limit");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    fraction_count <= FRAC_MAX)
    else $error("fraction count beyond digit limit");

  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (push.count == 2'd2) |-> (push.first.kind == KIND_NUMBER && push.second.kind != KIND_NUMBER))
    else $error("token pair is not a number followed by an operator");

endmodule

`default_nettype wire

@@ rtl/rpn_tok_queue.sv @@
// ---------------------------------------------------------------------------
// rpn_tok_queue
// Output queue of tokens. Takes zero, one or two tokens per cycle and hands
// one word per cycle to the output channel while a word waits and out_ready is high.
// ---------------------------------------------------------------------------
`default_nettype none

module rpn_tok_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire rpn_tok_pkg::push_t push,
  output logic                    room,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rpn_tok_pkg::token_t     token
);
  import rpn_tok_pkg::*;

  token_t            mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic [QCNT_W-1:0] count_next;
  logic              pop;

  assign out_valid  = (count != '0);
  assign pop        = out_valid & out_ready;
  assign room       = (count <= QCNT_W'(QUEUE_DEPTH - 2));
  assign token      = mem[rd_ptr];
  assign count_next = count + QCNT_W'(push.count) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.count);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + QPTR_W'(1)] <= push.second;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QUEUE_DEPTH))
    else $error("token queue count beyond depth");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> room)
    else $error("tokens pushed without room");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && count == QCNT_W'(1) && push.count == 2'd0) |=> !out_valid)
    else $error("queue not empty after last word taken");

endmodule

`default_nettype wire

@@ rtl/rpn_expression_tokenizer.sv @@
// ---------------------------------------------------------------------------
// rpn_expression_tokenizer
// Streaming lexer for arithmetic expression text.
//
// Input channel: one character (ch) per word, end_of_text on the last
// character of an expression. Output channel: one token per word; kind,
// mantissa, frac_digits, overflow, and last_of_run on the final token a
// character causes. A character yields zero, one or two tokens.
// The first token of a character passes the input register, then the token
// queue, before out_valid shows it.
// Throughput: one character per cycle while each yields at most one token
// and the receiver takes every token; a character yielding two tokens
// sends both through the single output port of the four-entry token queue.
// Reset clears the scan state and empties the queue; no number is pending.
// When the receiver stalls, the queue fills and in_ready drops once fewer
// than two entries are free; no token is lost.
// ---------------------------------------------------------------------------
`default_nettype none

module rpn_expression_tokenizer #(
  parameter int MAX_DIGITS = rpn_tok_pkg::DEF_MAX_DIGITS
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [7:0]                          ch,
  input  wire logic                                end_of_text,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic [rpn_tok_pkg::KIND_W-1:0]           kind,
  output logic [rpn_tok_pkg::MANT_W-1:0]           mantissa,
  output logic [rpn_tok_pkg::FRAC_W-1:0]           frac_digits,
  output logic                                     overflow,
  output logic                                     last_of_run
);
  import rpn_tok_pkg::*;

  push_t  push;
  logic   room;
  token_t token;

  rpn_tok_scan #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_scan (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .ch          (ch),
    .end_of_text (end_of_text),
    .room        (room),
    .push        (push)
  );

  rpn_tok_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .token     (token)
  );

  assign kind        = token.kind;
  assign mantissa    = token.mantissa;
  assign frac_digits = token.frac_digits;
  assign overflow    = token.overflow;
  assign last_of_run = token.last_of_run;

endmodule

`default_nettype wire

@@ bench/tb_rpn_expression_tokenizer.sv @@
// ---------------------------------------------------------------------------
// tb_rpn_expression_tokenizer
// Self-checking bench for the streaming expression tokenizer. A short table
// of directed characters covers every operator, byte extremes, fractions,
// stray and trailing dots and end-of-text flushes. Random expressions with
// long digit runs (mantissa and fraction saturation), whitespace and noise
// bytes follow. Each token is compared against the table's typed tokens or an
// in-bench lexer model while both handshakes idle at random, then at full rate.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rpn_expression_tokenizer;
  import rpn_tok_pkg::*;

  localparam int MAX_DIGITS = DEF_MAX_DIGITS;
  localparam int N_CHARS    = 1850;
  localparam int N_DIRECTED = 25;
  localparam int CYCLE_CAP  = 200000;

  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  function automatic logic [63:0] ten_pow(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  localparam logic [MANT_W-1:0] MANT_MAX = MANT_W'(ten_pow(MAX_DIGITS) - 64'd1);
  localparam token_t NO_TOK = '0;

  typedef enum logic [1:0] {LEX_IDLE, LEX_INT, LEX_DOT, LEX_FRAC} lex_mode_e;

  typedef struct packed {
    logic [7:0] c;
    logic       eot;
    int         n;
    token_t     t0;
    token_t     t1;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] ch = 8'd0;
  logic end_of_text = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KIND_W-1:0] kind;
  logic [MANT_W-1:0] mantissa;
  logic [FRAC_W-1:0] frac_digits;
  logic overflow;
  logic last_of_run;

  lex_mode_e         lex_mode = LEX_IDLE;
  logic [MANT_W-1:0] lex_value = '0;
  logic [FRAC_W-1:0] lex_frac = '0;
  logic              lex_sat = 1'b0;
  token_t            lex_out[$];
  token_t            tok_expect[$];
  logic [7:0]        text_q[$];
  logic              text_eot;
  stim_row_t         dir_tab [0:N_DIRECTED-1];

  int src_idle = 15;
  int snk_idle = 86;
  int err_cnt = 0;
  int chars_sent = 0;
  int tokens_seen = 0;
  int nums_seen = 0;
  int sat_seen = 0;
  int cycle_cnt = 0;

  rpn_expression_tokenizer i_dut (
    .clk, .rst, .in_valid, .in_ready, .ch, .end_of_text,
    .out_valid, .out_ready, .kind, .mantissa, .frac_digits, .overflow, .last_of_run
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic token_t mk_tok(input logic [KIND_W-1:0] k, input logic [MANT_W-1:0] m,
                                    input logic [FRAC_W-1:0] f, input logic ov,
                                    input logic last);
    token_t t;
    t.kind = k;
    t.mantissa = m;
    t.frac_digits = f;
    t.overflow = ov;
    t.last_of_run = last;
    return t;
  endfunction

  function automatic logic op_of(input logic [7:0] c, output logic [KIND_W-1:0] k);
    op_of = 1'b1;
    k = KIND_PLUS;
    case (c)
      CH_PLUS:    k = KIND_PLUS;
      CH_MINUS:   k = KIND_MINUS;
      CH_STAR:    k = KIND_STAR;
      CH_SLASH:   k = KIND_SLASH;
      CH_PERCENT: k = KIND_PERCENT;
      CH_COMMA:   k = KIND_COMMA;
      default:    op_of = 1'b0;
    endcase
  endfunction

  function automatic void lex_digit(input logic [3:0] d, input logic in_frac);
    if (lex_sat) return;
    if (lex_value > (MANT_MAX - d) / 10 || (in_frac && lex_frac >= MAX_DIGITS)) begin
      lex_sat = 1'b1;
      lex_value = MANT_MAX;
    end else begin
      lex_value = lex_value * 10 + d;
      if (in_frac) lex_frac = lex_frac + 1'b1;
    end
  endfunction

  function automatic void lex_flush();
    lex_out.push_back(mk_tok(KIND_NUMBER, lex_value, lex_frac, lex_sat, 1'b0));
    lex_mode = LEX_IDLE;
    lex_value = '0;
    lex_frac = '0;
    lex_sat = 1'b0;
  endfunction

  // Advance the lexer by one character; tokens land in lex_out.
  function automatic void lex_char(input logic [7:0] c, input logic eot);
    logic              is_dig;
    logic              is_op;
    logic              fresh;
    logic [3:0]        d;
    logic [KIND_W-1:0] op_kind;
    is_dig = c >= CH_ZERO && c <= CH_NINE;
    d = is_dig ? 4'(c - CH_ZERO) : 4'd0;
    is_op = op_of(c, op_kind);
    fresh = 1'b0;
    case (lex_mode)
      LEX_INT: begin
        if (is_dig) lex_digit(d, 1'b0);
        else if (c == CH_DOT) lex_mode = LEX_DOT;
        else begin
          lex_flush();
          fresh = 1'b1;
        end
      end
      LEX_DOT: begin
        if (is_dig) begin
          lex_mode = LEX_FRAC;
          lex_digit(d, 1'b1);
        end else begin
          lex_flush();
          fresh = 1'b1;
        end
      end
      LEX_FRAC: begin
        if (is_dig) lex_digit(d, 1'b1);
        else begin
          lex_flush();
          fresh = 1'b1;
        end
      end
      default: fresh = 1'b1;
    endcase
    if (fresh) begin
      if (is_op) lex_out.push_back(mk_tok(op_kind, '0, '0, 1'b0, 1'b0));
      else if (is_dig) begin
        lex_mode = LEX_INT;
        lex_value = '0;
        lex_frac = '0;
        lex_sat = 1'b0;
        lex_digit(d, 1'b0);
      end
    end
    if (eot && lex_mode != LEX_IDLE) lex_flush();
    if (lex_out.size() > 0) lex_out[lex_out.size()-1].last_of_run = 1'b1;
  endfunction

  task automatic flag_mismatch(input string what);
    err_cnt++;
    if (err_cnt <= 40) $display("%0t ns: mismatch: %s", $time, what);
  endtask

  // Entered and left at a falling edge.
  task automatic put_char(input logic [7:0] c, input logic e, input int n_typed,
                          input token_t t0, input token_t t1);
    while ($urandom_range(99) < src_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    end_of_text <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    chars_sent++;
    lex_out.delete();
    lex_char(c, e);
    if (n_typed < 0) begin
      foreach (lex_out[i]) tok_expect.push_back(lex_out[i]);
    end else begin
      if (n_typed > 0) tok_expect.push_back(t0);
      if (n_typed > 1) tok_expect.push_back(t1);
    end
    @(negedge clk);
  endtask

  function automatic logic [7:0] pick_space();
    case ($urandom_range(2))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      default: return CH_NL;
    endcase
  endfunction

  function automatic logic [7:0] pick_op();
    case ($urandom_range(5))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_STAR;
      3:       return CH_SLASH;
      4:       return CH_PERCENT;
      default: return CH_COMMA;
    endcase
  endfunction

  function automatic void add_digits(input int n);
    int style;
    style = $urandom_range(5);
    for (int i = 0; i < n; i++) begin
      case (style)
        0:       text_q.push_back(CH_NINE);
        1:       text_q.push_back(CH_ZERO);
        default: text_q.push_back(CH_ZERO + 8'($urandom_range(9)));
      endcase
    end
  endfunction

  function automatic int run_len(input int lo, input int hi);
    return ($urandom_range(9) == 0) ? $urandom_range(16, 20) : $urandom_range(lo, hi);
  endfunction

  function automatic void add_number();
    int r;
    add_digits(run_len(1, 4));
    r = $urandom_range(9);
    if (r < 4) begin
      text_q.push_back(CH_DOT);
      add_digits(run_len(1, 3));
      if ($urandom_range(19) == 0) text_q.push_back(CH_DOT);
    end else if (r == 4) begin
      text_q.push_back(CH_DOT);
    end
  endfunction

  function automatic void make_expr();
    int terms;
    terms = $urandom_range(1, 5);
    for (int t = 0; t < terms; t++) begin
      if ($urandom_range(3) == 0) text_q.push_back(pick_space());
      add_number();
      if ($urandom_range(3) == 0) text_q.push_back(pick_space());
      if (t < terms - 1 || $urandom_range(9) == 0) text_q.push_back(pick_op());
    end
    text_eot = 1'b1;
  endfunction

  function automatic void make_noise();
    int n;
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) text_q.push_back(8'($urandom_range(255)));
    text_eot = 1'($urandom_range(1));
  endfunction

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    token_t want;
    if (!rst && out_valid && out_ready) begin
      tokens_seen++;
      if (kind == KIND_NUMBER) nums_seen++;
      if (overflow) sat_seen++;
      if (tok_expect.size() == 0) begin
        flag_mismatch($sformatf("unexpected word, kind %0d mantissa %0d", kind, mantissa));
      end else begin
        want = tok_expect.pop_front();
        if (kind !== want.kind)
          flag_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
        if (mantissa !== want.mantissa)
          flag_mismatch($sformatf("mantissa %0d, want %0d", mantissa, want.mantissa));
        if (frac_digits !== want.frac_digits)
          flag_mismatch($sformatf("frac_digits %0d, want %0d", frac_digits, want.frac_digits));
        if (overflow !== want.overflow)
          flag_mismatch($sformatf("overflow %0b, want %0b", overflow, want.overflow));
        if (last_of_run !== want.last_of_run)
          flag_mismatch($sformatf("last_of_run %0b, want %0b", last_of_run, want.last_of_run));
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_CAP) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_rpn_expression_tokenizer: FAIL");
    $finish;
  end

  initial begin
    int rand_chars;
    dir_tab = '{
      '{CH_PLUS,    1'b0, 1, mk_tok(KIND_PLUS, '0, '0, 1'b0, 1'b1), NO_TOK},
      '{CH_MINUS,   1'b0, 1, mk_tok(KIND_MINUS, '0, '0, 1'b0, 1'b1), NO_TOK},
      '{CH_STAR,    1'b0, 1, mk_tok(KIND_STAR, '0, '0, 1'b0, 1'b1), NO_TOK},
      '{CH_SLASH,   1'b0, 1, mk_tok(KIND_SLASH, '0, '0, 1'b0, 1'b1), NO_TOK},
      '{CH_PERCENT, 1'b0, 1, mk_tok(KIND_PERCENT, '0, '0, 1'b0, 1'b1), NO_TOK},
      '{CH_COMMA,   1'b0, 1, mk_tok(KIND_COMMA, '0, '0, 1'b0, 1'b1), NO_TOK},
      '{8'h00,      1'b1, 0, NO_TOK, NO_TOK},
      '{8'hFF,      1'b0, 0, NO_TOK, NO_TOK},
      '{CH_NINE,    1'b0, 0, NO_TOK, NO_TOK},
      '{CH_DOT,     1'b0, 0, NO_TOK, NO_TOK},
      '{"5",        1'b1, 1, mk_tok(KIND_NUMBER, 60'd95, 5'd1, 1'b0, 1'b1), NO_TOK},
      '{"7",        1'b0, 0, NO_TOK, NO_TOK},
      '{CH_DOT,     1'b0, 0, NO_TOK, NO_TOK},
      '{CH_PLUS,    1'b0, 2, mk_tok(KIND_NUMBER, 60'd7, '0, 1'b0, 1'b0),
                             mk_tok(KIND_PLUS, '0, '0, 1'b0, 1'b1)},
      '{"3",        1'b0, -1, NO_TOK, NO_TOK},
      '{CH_DOT,     1'b0, -1, NO_TOK, NO_TOK},
      '{"4",        1'b0, -1, NO_TOK, NO_TOK},
      '{CH_DOT,     1'b0, -1, NO_TOK, NO_TOK},
      '{CH_DOT,     1'b1, -1, NO_TOK, NO_TOK},
      '{CH_ZERO,    1'b1, 1, mk_tok(KIND_NUMBER, '0, '0, 1'b0, 1'b1), NO_TOK},
      '{CH_SPACE,   1'b0, -1, NO_TOK, NO_TOK},
      '{"8",        1'b0, -1, NO_TOK, NO_TOK},
      '{CH_TAB,     1'b0, -1, NO_TOK, NO_TOK},
      '{"6",        1'b0, -1, NO_TOK, NO_TOK},
      '{CH_DOT,     1'b1, -1, NO_TOK, NO_TOK}
    };
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      put_char(dir_tab[i].c, dir_tab[i].eot, dir_tab[i].n, dir_tab[i].t0, dir_tab[i].t1);
    end

    rand_chars = 0;
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle = 15;
          snk_idle = 86;
        end
        1: begin
          src_idle = 86;
          snk_idle = 15;
        end
        default: begin
          src_idle = 0;
          snk_idle = 0;
        end
      endcase
      while (rand_chars < N_CHARS * (phase + 1) / 3) begin
        text_q.delete();
        if ($urandom_range(9) == 0) make_noise();
        else make_expr();
        foreach (text_q[i]) begin
          put_char(text_q[i], (i == text_q.size() - 1) ? text_eot : 1'b0, -1, NO_TOK, NO_TOK);
        end
        rand_chars += text_q.size();
      end
    end
    in_valid <= 1'b0;

    while (tok_expect.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tok_expect.size() != 0)
      flag_mismatch($sformatf("%0d tokens never arrived", tok_expect.size()));

    $display("Sent %0d characters; got %0d tokens, %0d numbers, %0d saturated.",
             chars_sent, tokens_seen, nums_seen, sat_seen);
    $display("Sender and receiver idled in turn, then ran at full rate; %0d mismatches.",
             err_cnt);
    if (err_cnt == 0) begin
      $display("tb_rpn_expression_tokenizer: PASS");
    end else begin
      $display("tb_rpn_expression_tokenizer: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/rpn_tok_pkg.sv
rtl/rpn_tok_scan.sv
rtl/rpn_tok_queue.sv
rtl/rpn_expression_tokenizer.sv
bench/tb_rpn_expression_tokenizer.sv
